@@ rtl/otq_pkg.sv @@
// shared constants, types and helpers of the overlay timing queue
package otq_pkg;

  // ring geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // fixed field widths
  localparam int TIME_W     = 62;
  localparam int ACT_W      = 3;
  localparam int IDX_W      = 4;
  localparam int POS_W      = 4;
  localparam int STAT_W     = 2;
  localparam int CNT_OUT_W  = 5;
  localparam int MAXE_W     = 5;
  localparam int HOR_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [MAXE_W-1:0] MAXE_RESET = 5'd16;
  localparam logic [HOR_W-1:0]  HOR_RESET  = 32'd600000000;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SET_TIME   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INVALIDATE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STATS      = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_REJECT    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON     = 1'd1;

  // one stored interval
  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
  } entry_t;

  // request from the sequencer to the interval memory
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  // ring slot of a position counted from the head
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                input logic [CNT_W-1:0]  pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(SLOTS)) begin
      sum = sum - (CNT_W+1)'(SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

@@ rtl/otq_in_if.sv @@
// command channel of the overlay timing queue
interface otq_in_if import otq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [TIME_W-1:0] time_value;
  logic [TIME_W-1:0] new_start;
  logic [TIME_W-1:0] new_stop;
  logic [IDX_W-1:0]  entry_index;

  modport source (output valid, action, time_value, new_start, new_stop, entry_index,
                  input ready);
  modport sink (input valid, action, time_value, new_start, new_stop, entry_index,
                output ready);
endinterface

@@ rtl/otq_out_if.sv @@
// reply channel of the overlay timing queue
interface otq_out_if import otq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic                 hit;
  logic [POS_W-1:0]     hit_position;
  logic [TIME_W-1:0]    slot_start;
  logic [TIME_W-1:0]    slot_stop;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [TIME_W-1:0]    fill_from;

  modport source (output valid, status, hit, hit_position, slot_start, slot_stop,
                  entry_count, fill_from, input ready);
  modport sink (input valid, status, hit, hit_position, slot_start, slot_stop,
                entry_count, fill_from, output ready);
endinterface

@@ rtl/otq_ram.sv @@
// simple dual-port memory, one write and one registered read port
module otq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/otq_ctrl.sv @@
// command sequencer: queue pointers, walks over the interval memory, reply register
module otq_ctrl import otq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  otq_in_if.sink                in_if,
  otq_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output mem_req_t              mem_req,
  input  entry_t                mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_STATS = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TIME_W-1:0]   cur_time_r, cur_time_nxt;
  logic [TIME_W-1:0]   qstart_r, qstart_nxt;
  logic [TIME_W-1:0]   tail_r, tail_nxt;
  logic [MAXE_W-1:0]   maxe_r, maxe_nxt;
  logic [HOR_W-1:0]    hor_r, hor_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    ik_r, ik_nxt;
  logic [CNT_W-1:0]    ck_r, ck_nxt;
  logic                cval_r, cval_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic                res_hit_r, res_hit_nxt;
  logic [POS_W-1:0]    res_pos_r, res_pos_nxt;
  logic [TIME_W-1:0]   res_start_r, res_start_nxt;
  logic [TIME_W-1:0]   res_stop_r, res_stop_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r;
  logic                out_hit_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [TIME_W-1:0]   out_start_r;
  logic [TIME_W-1:0]   out_stop_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic [TIME_W-1:0]   out_fill_r;

  logic                in_fire;
  logic                out_load;
  logic [TIME_W-1:0]   fill_w;
  logic [TIME_W:0]     limit_w;
  logic                full_w;
  logic                reject_w;
  logic [CNT_W-1:0]    ipos_w;
  logic [CNT_W-1:0]    cpos_w;
  logic                in_range_w;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = (state_r == S_FIN) && (!out_valid_r || out_if.ready);

  // fill point: tail stop, or the current time when empty
  assign fill_w = (count_r != '0) ? tail_r : cur_time_r;

  // append admission checks
  assign limit_w  = {1'b0, cur_time_r} + (TIME_W+1)'(hor_r);
  assign full_w   = (32'(count_r) >= 32'(maxe_r)) || (32'(count_r) >= 32'(SLOTS));
  assign reject_w = ((cur_time_r >= in_if.new_start) && (cur_time_r >= in_if.new_stop)) ||
                    ((TIME_W+1)'(in_if.new_start) >= limit_w) ||
                    (in_if.new_stop <= fill_w);

  // walk positions: forward from head, or backward from tail for invalidate
  assign ipos_w = (ik_r >= count_r) ? '0 :
                  (act_r == ACT_INVALIDATE) ? (count_r - CNT_W'(1) - ik_r) : ik_r;
  assign cpos_w = (ck_r >= count_r) ? '0 :
                  (act_r == ACT_INVALIDATE) ? (count_r - CNT_W'(1) - ck_r) : ck_r;
  assign in_range_w = (ck_r < count_r);

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    cur_time_nxt   = cur_time_r;
    qstart_nxt     = qstart_r;
    tail_nxt       = tail_r;
    maxe_nxt       = maxe_r;
    hor_nxt        = hor_r;
    act_nxt        = act_r;
    t_nxt          = t_r;
    idx_nxt        = idx_r;
    ik_nxt         = ik_r;
    ck_nxt         = ck_r;
    cval_nxt       = cval_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_pos_nxt    = res_pos_r;
    res_start_nxt  = res_start_r;
    res_stop_nxt   = res_stop_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    mem_req.we     = 1'b0;
    mem_req.waddr  = slot_of(head_r, count_r);
    mem_req.wdata  = '{start: in_if.new_start, stop: in_if.new_stop};
    mem_req.raddr  = (state_r == S_IDLE) ? slot_of(head_r, CNT_W'(in_if.entry_index))
                                         : slot_of(head_r, ipos_w);

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ENTRIES: maxe_nxt = cfg_wdata[MAXE_W-1:0];
        REG_HORIZON:     hor_nxt  = cfg_wdata[HOR_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      // take a transaction and settle the short commands at once
      S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_if.action;
          t_nxt          = in_if.time_value;
          idx_nxt        = in_if.entry_index;
          ik_nxt         = '0;
          cval_nxt       = 1'b0;
          res_status_nxt = ST_OK;
          res_hit_nxt    = 1'b0;
          res_pos_nxt    = '0;
          res_start_nxt  = '0;
          res_stop_nxt   = '0;
          state_nxt      = S_FIN;
          case (in_if.action)
            ACT_SET_TIME: begin
              cur_time_nxt = in_if.time_value;
              qstart_nxt   = in_if.time_value;
              if (in_if.time_value < qstart_r) begin
                count_nxt = '0;
              end else begin
                state_nxt = S_WALK;
              end
            end
            ACT_APPEND: begin
              if (full_w) begin
                res_status_nxt = ST_FULL;
              end else if (reject_w) begin
                res_status_nxt = ST_REJECT;
              end else begin
                mem_req.we = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                tail_nxt   = in_if.new_stop;
              end
            end
            ACT_LOOKUP, ACT_INVALIDATE: begin
              state_nxt = S_WALK;
            end
            ACT_STATS: begin
              if (32'(in_if.entry_index) < 32'(count_r)) begin
                state_nxt = S_STATS;
              end else begin
                res_status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              res_status_nxt = ST_NOT_FOUND;
            end
          endcase
        end
      end

      // one read issued per cycle, the previous one checked
      S_WALK: begin
        ik_nxt   = (ik_r >= count_r) ? ik_r : ik_r + CNT_W'(1);
        ck_nxt   = ik_r;
        cval_nxt = 1'b1;
        if (cval_r) begin
          case (act_r)
            ACT_SET_TIME: begin
              if (!in_range_w || (t_r < mem_rdata.stop)) begin
                head_nxt  = slot_of(head_r, ck_r);
                count_nxt = count_r - ck_r;
                cval_nxt  = 1'b0;
                state_nxt = S_FIN;
              end
            end
            ACT_LOOKUP: begin
              if (!in_range_w) begin
                res_status_nxt = ST_NOT_FOUND;
                cval_nxt       = 1'b0;
                state_nxt      = S_FIN;
              end else if ((mem_rdata.start <= t_r) && (t_r < mem_rdata.stop)) begin
                res_status_nxt = ST_OK;
                res_hit_nxt    = 1'b1;
                res_pos_nxt    = POS_W'(ck_r);
                res_start_nxt  = mem_rdata.start;
                res_stop_nxt   = mem_rdata.stop;
                cval_nxt       = 1'b0;
                state_nxt      = S_FIN;
              end
            end
            ACT_INVALIDATE: begin
              if (!in_range_w) begin
                count_nxt = '0;
                cval_nxt  = 1'b0;
                state_nxt = S_FIN;
              end else if (mem_rdata.stop <= t_r) begin
                count_nxt = count_r - ck_r;
                tail_nxt  = mem_rdata.stop;
                cval_nxt  = 1'b0;
                state_nxt = S_FIN;
              end else if (mem_rdata.start < t_r) begin
                // trim the tail entry to end at the given time
                mem_req.we    = 1'b1;
                mem_req.waddr = slot_of(head_r, cpos_w);
                mem_req.wdata = '{start: mem_rdata.start, stop: t_r};
                count_nxt     = count_r - ck_r;
                tail_nxt      = t_r;
                cval_nxt      = 1'b0;
                state_nxt     = S_FIN;
              end
            end
            default: begin
              cval_nxt  = 1'b0;
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // entry read by position
      S_STATS: begin
        res_pos_nxt   = POS_W'(idx_r);
        res_start_nxt = mem_rdata.start;
        res_stop_nxt  = mem_rdata.stop;
        state_nxt     = S_FIN;
      end

      // hand the reply to the output register once it is free
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      cur_time_r  <= '0;
      qstart_r    <= '0;
      maxe_r      <= MAXE_RESET;
      hor_r       <= HOR_RESET;
      cval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cur_time_r  <= cur_time_nxt;
      qstart_r    <= qstart_nxt;
      maxe_r      <= maxe_nxt;
      hor_r       <= hor_nxt;
      cval_r      <= cval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // transaction and reply payload
  always_ff @(posedge clk) begin
    tail_r       <= tail_nxt;
    act_r        <= act_nxt;
    t_r          <= t_nxt;
    idx_r        <= idx_nxt;
    ik_r         <= ik_nxt;
    ck_r         <= ck_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_pos_r    <= res_pos_nxt;
    res_start_r  <= res_start_nxt;
    res_stop_r   <= res_stop_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_hit_r    <= res_hit_r;
      out_pos_r    <= res_pos_r;
      out_start_r  <= res_start_r;
      out_stop_r   <= res_stop_r;
      out_count_r  <= CNT_OUT_W'(count_r);
      out_fill_r   <= fill_w;
    end
  end

  // reply channel
  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.hit          = out_hit_r;
  assign out_if.hit_position = out_pos_r;
  assign out_if.slot_start   = out_start_r;
  assign out_if.slot_stop    = out_stop_r;
  assign out_if.entry_count  = out_count_r;
  assign out_if.fill_from    = out_fill_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(SLOTS))
    else $error("entry count beyond ring size");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && cval_r) |-> (ck_r <= count_r))
    else $error("walk checked past the held entries");

  a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> ((in_fire && in_if.action == ACT_APPEND) ||
                    (state_r == S_WALK && act_r == ACT_INVALIDATE)))
    else $error("memory written outside append or trim");

  a_head_move: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && head_r != $past(head_r)) |->
      $past(state_r == S_WALK && act_r == ACT_SET_TIME))
    else $error("head moved outside expiry walk");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("reply raised without a finished transaction");
`endif

endmodule

@@ rtl/timestamped_overlay_queue_top.sv @@
// Overlay timing queue: keeps a ring of display intervals and answers commands on them.
//
// in_if carries one command transaction (set_time, append, lookup, invalidate, entry
// read); out_if returns exactly one reply transaction per command, in order. Both use
// valid/ready and move a transaction at a clock edge with both high. cfg_we, cfg_index
// and cfg_wdata write max_entries (index 0) and lookahead_horizon (index 1); the user must
// write them only while no command is in flight, which the block itself does not enforce.
// Append, entry read, clears and unused codes are settled without a walk over the ring.
// Set_time, lookup and invalidate walk the ring one entry per cycle through the single
// read port of the interval memory. One command is worked on at a time; a new one is
// taken in the cycle after the previous reply moves into the output register.
// The output register holds a reply while the receiver stalls; the next command is
// still taken and worked on, and its reply waits until the register is free.
// Reset (rst_n low, synchronous) empties the queue, zeroes the current time and loads
// the register defaults; the interval memory itself is not cleared.
module timestamped_overlay_queue_top import otq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  otq_in_if.sink                in_if,
  otq_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  mem_req_t mem_req;
  entry_t   mem_rdata;

  // command sequencer
  otq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // interval memory
  otq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule
